### hdl/bounded_set_min_max_gap_core_defines.svh
// assertion macros for the bounded set span core
`ifndef BOUNDED_SET_MIN_MAX_GAP_CORE_DEFINES_SVH
`define BOUNDED_SET_MIN_MAX_GAP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// plain property, sampled on clk, off during reset
`define BSMMG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsmmg assertion failed");
// same-cycle implication
`define BSMMG_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bsmmg implication failed");
// next-cycle implication
`define BSMMG_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bsmmg next-cycle implication failed");
`else
`define BSMMG_ASSERT(lbl, prop)
`define BSMMG_ASSERT_IMP(lbl, pre, post)
`define BSMMG_ASSERT_NXT(lbl, pre, post)
`endif
`endif

### hdl/bsmmg_pkg.sv
// shared types and codes of the bounded set span core
`timescale 1ns / 1ps
package bsmmg_pkg;

  typedef logic [1:0] op_t;
  localparam op_t OP_GAP  = 2'd0;
  localparam op_t OP_MIN  = 2'd1;
  localparam op_t OP_MAX  = 2'd2;
  localparam op_t OP_SPAN = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_STORED  = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_CLEARED = 2'd2;

  localparam int          CAP_W     = 11;
  localparam int          VAL_W     = 32;
  localparam int          GAP_W     = 33;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [GAP_W-1:0] GAP_INIT  = {GAP_W{1'b1}};

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             ge;
    logic [GAP_W-1:0] mag;
  } unit_rsp_t;

endpackage

### hdl/bsmmg_store.sv
// value store: one write port, one registered read port
`timescale 1ns / 1ps
module bsmmg_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data,
  output logic              rd_valid
);
  import bsmmg_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

### hdl/bsmmg_diff_unit.sv
// shared signed compare and magnitude-of-difference unit, registered result
`timescale 1ns / 1ps
module bsmmg_diff_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsmmg_pkg::unit_req_t  req,
  output bsmmg_pkg::unit_rsp_t  rsp
);
  import bsmmg_pkg::*;

  logic [GAP_W-1:0] a_x;
  logic [GAP_W-1:0] b_x;
  logic             ge;
  logic [GAP_W-1:0] mag;

  logic             valid_r;
  op_t              op_r;
  logic             ge_r;
  logic [GAP_W-1:0] mag_r;

  // sign-extend so the difference is exact
  assign a_x = {req.a[VAL_W-1], req.a};
  assign b_x = {req.b[VAL_W-1], req.b};
  assign ge  = $signed(a_x) >= $signed(b_x);
  assign mag = ge ? (a_x - b_x) : (b_x - a_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= req.op;
    ge_r  <= ge;
    mag_r <= mag;
  end

  assign rsp = '{valid: valid_r, op: op_r, ge: ge_r, mag: mag_r};

endmodule

### hdl/bounded_set_min_max_gap_core.sv
// top level of the bounded set span core: sequencer, state and result register
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  in_      | sink      | in_tvalid/in_tready  | tuser: mode ; tdata: value
//  out_     | source    | out_tvalid/out_tready| tuser: status ; tdata: count, spans
//  cfg_     | sink      | cfg_wr_en            | cfg_wr_data: capacity
//
//  clear, rejected add and add to an empty set: straight to the result state, then into the result register
//  add to a set of n values: the scan reads one stored value per
//    cycle from the single read port of the store and runs it through the shared unit
//  min, max and longest span then take one pass each through the same unit
//  rst_n is synchronous; the store is not cleared, only entries below the count are read
//  a finished result sits in the output register while the next request is taken;
//    that request's result waits until the output register is free
`timescale 1ns / 1ps
`include "bounded_set_min_max_gap_core_defines.svh"
module bounded_set_min_max_gap_core #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [10:0] count, [11] span_valid, [43:12] shortest_span,
                                  // [75:44] longest_span, [79:76] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // capacity register
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);
  import bsmmg_pkg::*;

  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] MIN_FOR_SPAN = CNT_W'(2);

  // sequencer codes
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_MIN       = 3'd2;
  localparam logic [2:0] S_MAX       = 3'd3;
  localparam logic [2:0] S_SETTLE    = 3'd4;
  localparam logic [2:0] S_SPAN      = 3'd5;
  localparam logic [2:0] S_SPAN_WAIT = 3'd6;
  localparam logic [2:0] S_RESULT    = 3'd7;

  logic [2:0]        state_r,  state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  held_r,   held_nxt;
  logic [VAL_W-1:0]  small_r,  small_nxt;
  logic [VAL_W-1:0]  large_r,  large_nxt;
  logic [GAP_W-1:0]  gap_r,    gap_nxt;
  logic [VAL_W-1:0]  span_r,   span_nxt;
  logic [VAL_W-1:0]  value_r,  value_nxt;
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] idx_r,    idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [79:0]       out_data_r,  out_data_nxt;
  status_t           out_user_r,  out_user_nxt;

  logic              in_fire;
  logic [CMP_W-1:0]  limit;
  logic              set_full;
  logic              load_out;
  logic              span_ok;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;
  logic              rd_valid;

  unit_req_t         u_req;
  unit_rsp_t         u_rsp;

  bsmmg_store #(
    .DEPTH  (MAX_ITEMS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  bsmmg_diff_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (u_req),
    .rsp   (u_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // effective capacity is the smaller of the register and the store depth
  assign limit    = (CMP_W'(cap_r) > MAX_C) ? MAX_C : CMP_W'(cap_r);
  assign set_full = CMP_W'(held_r) >= limit;

  // result register frees up when empty or when the current result is taken
  assign load_out = (state_r == S_RESULT) && (!out_valid_r || out_tready);
  assign span_ok  = held_r >= MIN_FOR_SPAN;

  // shared unit operand selection: scan reads have priority
  always_comb begin
    u_req = '{valid: 1'b0, op: OP_GAP, a: value_r, b: rd_data};
    if (rd_valid) begin
      u_req.valid = 1'b1;
    end else begin
      unique case (state_r)
        S_MIN: begin
          // value below smallest when not ge
          u_req = '{valid: 1'b1, op: OP_MIN, a: value_r, b: small_r};
        end
        S_MAX: begin
          // value above largest when not ge
          u_req = '{valid: 1'b1, op: OP_MAX, a: large_r, b: value_r};
        end
        S_SPAN: begin
          u_req = '{valid: 1'b1, op: OP_SPAN, a: large_r, b: small_r};
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer and set state
  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    small_nxt  = small_r;
    large_nxt  = large_r;
    gap_nxt    = gap_r;
    span_nxt   = span_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = held_r[ADDR_W-1:0];
    wr_data    = value_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;

    // results coming back from the shared unit
    if (u_rsp.valid) begin
      unique case (u_rsp.op)
        OP_GAP: begin
          if (u_rsp.mag < gap_r) begin
            gap_nxt = u_rsp.mag;
          end
        end
        OP_MIN: begin
          if (!u_rsp.ge) begin
            small_nxt = value_r;
          end
        end
        OP_MAX: begin
          if (!u_rsp.ge) begin
            large_nxt = value_r;
          end
        end
        OP_SPAN: begin
          span_nxt = u_rsp.mag[VAL_W-1:0];
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          value_nxt = in_tdata;
          idx_nxt   = '0;
          if (in_tuser[0]) begin
            held_nxt   = '0;
            small_nxt  = '0;
            large_nxt  = '0;
            gap_nxt    = GAP_INIT;
            span_nxt   = '0;
            status_nxt = ST_CLEARED;
            state_nxt  = S_RESULT;
          end else if (set_full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESULT;
          end else if (held_r == '0) begin
            // first value: nothing to compare against
            small_nxt  = in_tdata;
            large_nxt  = in_tdata;
            wr_en      = 1'b1;
            wr_data    = in_tdata;
            held_nxt   = CNT_W'(1);
            status_nxt = ST_STORED;
            state_nxt  = S_RESULT;
          end else begin
            status_nxt = ST_STORED;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (CNT_W'(idx_r) == held_r - CNT_W'(1)) begin
          state_nxt = S_MIN;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      S_MIN: begin
        // wait for the last scan read to pass the unit input
        if (!rd_valid) begin
          state_nxt = S_MAX;
        end
      end
      S_MAX: begin
        state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        wr_en     = 1'b1;
        held_nxt  = held_r + CNT_W'(1);
        state_nxt = S_SPAN_WAIT;
      end
      S_SPAN_WAIT: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = status_r;
      out_data_nxt  = {4'd0,
                       span_ok ? span_r : {VAL_W{1'b0}},
                       span_ok ? gap_r[VAL_W-1:0] : {VAL_W{1'b0}},
                       span_ok,
                       CAP_W'(held_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      held_r      <= '0;
      small_r     <= '0;
      large_r     <= '0;
      gap_r       <= GAP_INIT;
      span_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      small_r     <= small_nxt;
      large_r     <= large_nxt;
      gap_r       <= gap_nxt;
      span_r      <= span_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    status_r   <= status_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // the count never passes the store depth
  `BSMMG_ASSERT(a_held_bounded, held_r <= CNT_W'(MAX_ITEMS))
  // the scan only reads entries that have been written
  `BSMMG_ASSERT_IMP(a_read_below_count, rd_en, CNT_W'(rd_addr) < held_r)
  // a clear request empties the set by the next cycle
  `BSMMG_ASSERT_NXT(a_clear_empties, in_fire && in_tuser[0], held_r == '0)
  // nothing is left in flight in the shared unit once the sequencer is idle
  `BSMMG_ASSERT_IMP(a_unit_quiet_idle, state_r == S_IDLE, !u_rsp.valid && !rd_valid)

endmodule

### verif/bounded_set_min_max_gap_core_test.sv
// self-checking testbench of the bounded set span core: capacity rules, spans and stream flow
`timescale 1ns / 1ps
module bounded_set_min_max_gap_core_test;
  import bsmmg_pkg::*;

  localparam int MAX_ITEMS        = 1024;
  localparam int MIN_FOR_SPAN     = 2;     // values needed before spans mean anything
  localparam int QUIET_LIMIT      = 8000;  // allows for a full scan, plus the long hold
  localparam int HOLD_CYCLES      = 300;
  localparam int SEGMENT_REQUESTS = 33;
  localparam int IDLE_HEAVY       = 80;
  localparam int IDLE_LIGHT       = 13;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [VAL_W-1:0] VALUE_MOST_NEG = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VALUE_MOST_POS = 32'h7FFF_FFFF;
  localparam logic [CAP_W-1:0] CAP_HIGHEST    = 11'd2047;

  // one result as the block should report it
  typedef struct {
    status_t          status;
    logic [CAP_W-1:0] count;
    logic             span_valid;
    logic [31:0]      shortest;
    logic [31:0]      longest;
  } span_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [0:0]  in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // [10:0] count, [11] span_valid, [43:12] shortest_span,
                           // [75:44] longest_span, [79:76] zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;

  bounded_set_min_max_gap_core #(.MAX_ITEMS(MAX_ITEMS)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow copy of the set, kept in step with every accepted request
  longint           held_values[$];
  longint           smallest_held;
  longint           largest_held;
  longint           tightest_gap;
  logic [CAP_W-1:0] set_capacity;

  // reports still owed by the block, oldest first
  span_report_t pending_span_reports[$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_request    = 0;
  int quiet_cycles    = 0;
  int mismatches      = 0;
  int requests_sent   = 0;
  int results_seen    = 0;
  int rejected_adds   = 0;
  int capacity_writes = 0;
  int peak_count      = 0;

  initial begin
    clk = 1'b1;
    forever #6 clk = ~clk;
  end

  // apply one request to the shadow set and work out the report it causes
  function automatic span_report_t next_span_report(input logic mode, input logic [31:0] raw);
    span_report_t rep;
    longint       v;
    longint       d;
    int unsigned  limit;
    v     = longint'(signed'(raw));
    limit = (set_capacity > MAX_ITEMS) ? MAX_ITEMS : set_capacity;
    if (mode == MODE_CLEAR) begin
      held_values.delete();
      smallest_held = 0;
      largest_held  = 0;
      tightest_gap  = longint'(GAP_INIT);
      rep.status    = ST_CLEARED;
    end else if (held_values.size() >= limit) begin
      // full, or capacity lowered under the count: the set stays as it is
      rep.status = ST_FULL;
    end else begin
      // new value against every held one, as the block scans its store
      foreach (held_values[i]) begin
        d = (v >= held_values[i]) ? v - held_values[i] : held_values[i] - v;
        if (d < tightest_gap) tightest_gap = d;
      end
      if (held_values.size() == 0) begin
        smallest_held = v;
        largest_held  = v;
      end else begin
        if (v < smallest_held) smallest_held = v;
        if (v > largest_held) largest_held = v;
      end
      held_values = {held_values, v};
      rep.status = ST_STORED;
    end
    rep.count = CAP_W'(held_values.size());
    if (held_values.size() >= MIN_FOR_SPAN) begin
      rep.span_valid = 1'b1;
      rep.shortest   = tightest_gap[31:0];
      rep.longest    = 32'(largest_held - smallest_held);
    end else begin
      // spans read as zero below two values
      rep.span_valid = 1'b0;
      rep.shortest   = '0;
      rep.longest    = '0;
    end
    return rep;
  endfunction

  // mix of wide random values, near neighbours, repeats and extremes
  function automatic logic [31:0] pick_value();
    logic [31:0] pick;
    logic [31:0] anchor;
    if (held_values.size() != 0)
      anchor = 32'(held_values[$urandom_range(held_values.size() - 1)]);
    else
      anchor = $urandom();
    case ($urandom_range(9)) inside
      [0:2]:   pick = $urandom();
      [3:5]:   pick = anchor + $urandom_range(64) - 32;
      6:       pick = anchor;
      7: begin
        case ($urandom_range(3))
          0:       pick = VALUE_MOST_NEG;
          1:       pick = VALUE_MOST_POS;
          2:       pick = '0;
          default: pick = '1;
        endcase
      end
      default: pick = $urandom_range(2000) - 1000;
    endcase
    return pick;
  endfunction

  // mostly small capacities so sets fill up, now and then the extremes
  function automatic logic [CAP_W-1:0] pick_capacity();
    logic [CAP_W-1:0] pick;
    case ($urandom_range(11))
      0:       pick = '0;
      1:       pick = 11'd1;
      2:       pick = CAP_HIGHEST;
      3:       pick = CAP_RESET;
      4:       pick = CAP_W'($urandom_range(2047));
      default: pick = CAP_W'($urandom_range(2, 40));
    endcase
    return pick;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic reset_set_model();
    held_values.delete();
    smallest_held = 0;
    largest_held  = 0;
    tightest_gap  = longint'(GAP_INIT);
    set_capacity  = CAP_RESET;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // entered and left at a falling edge; valid stays up when the next request follows at once
  task automatic send_request(input logic mode, input logic [31:0] value);
    span_report_t rep;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rep = next_span_report(mode, value);
    pending_span_reports = {pending_span_reports, rep};
    requests_sent++;
    if (rep.status == ST_FULL) rejected_adds++;
    if (rep.count > peak_count) peak_count = int'(rep.count);
    @(negedge clk);
  endtask

  // drop valid at once and wait until every report owed has come back
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (pending_span_reports.size() != 0) @(negedge clk);
  endtask

  // register writes only while the block has nothing in flight
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_until_drained();
    cfg_wr_data <= cap;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    set_capacity = cap;
    capacity_writes++;
  endtask

  // extremes of the value field, repeats and spans with fewer than two values
  task automatic test_span_corner_values();
    set_idling(0, 0);
    send_request(MODE_ADD, 32'd5);            // single value, spans not valid
    send_request(MODE_CLEAR, '1);             // clear of a one-value set, value ignored
    send_request(MODE_ADD, 32'd5);
    send_request(MODE_ADD, 32'd5);            // repeat makes the shortest span zero
    send_request(MODE_ADD, VALUE_MOST_NEG);
    send_request(MODE_ADD, VALUE_MOST_POS);   // longest span all ones
    send_request(MODE_ADD, 32'd100);
    send_request(MODE_CLEAR, VALUE_MOST_POS);
    send_request(MODE_ADD, VALUE_MOST_POS);
    send_request(MODE_ADD, VALUE_MOST_NEG);   // both spans at their widest
    send_request(MODE_ADD, '1);
    send_request(MODE_CLEAR, '0);
  endtask

  // zero capacity, a full set, capacity dropped under the count, capacity past MAX_ITEMS
  task automatic test_capacity_rules();
    write_capacity('0);
    send_request(MODE_ADD, 32'd7);
    send_request(MODE_ADD, VALUE_MOST_NEG);
    write_capacity(11'd8);
    repeat (6) send_request(MODE_ADD, pick_value());
    write_capacity(11'd3);
    send_request(MODE_ADD, 32'd1);            // refused, held values stay
    send_request(MODE_ADD, VALUE_MOST_POS);
    send_request(MODE_CLEAR, '0);
    repeat (4) send_request(MODE_ADD, pick_value());  // last one finds the set full and is refused
    write_capacity(CAP_HIGHEST);
    send_request(MODE_ADD, 32'd9);
    send_request(MODE_CLEAR, '0);
    write_capacity(CAP_RESET);
  endtask

  // result side held off while requests keep coming, so the block must stall its input
  task automatic test_output_backpressure();
    set_idling(0, 0);
    wait_until_drained();
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    repeat (8) begin
      send_request(MODE_CLEAR, $urandom());
      send_request(MODE_ADD, pick_value());
    end
    wait_until_drained();
  endtask

  // random traffic under four idling mixes, a new capacity for every segment
  task automatic test_random_streams();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(IDLE_HEAVY, 0);
        2:       set_idling(0, IDLE_HEAVY);
        default: set_idling(IDLE_LIGHT, IDLE_LIGHT);
      endcase
      repeat (4) begin
        // set is kept across segments, so capacity may land under the count
        write_capacity(pick_capacity());
        repeat (SEGMENT_REQUESTS) begin
          if ($urandom_range(99) < 8)
            send_request(MODE_CLEAR, $urandom());
          else
            send_request(MODE_ADD, pick_value());
        end
      end
    end
  endtask

  // result side: random stalls, or a long hold when one is asked for
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // each report against the oldest one owed, field by field
  always @(posedge clk) begin : check_reports
    span_report_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      results_seen++;
      if (pending_span_reports.size() == 0) begin
        $error("result with no request outstanding: status %0d count %0d",
               out_tuser, out_tdata[10:0]);
        mismatches++;
      end else begin
        want = pending_span_reports.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("count", 32'(want.count), 32'(out_tdata[10:0]));
        check_field("span_valid", 32'(want.span_valid), 32'(out_tdata[11]));
        check_field("shortest_span", want.shortest, out_tdata[43:12]);
        check_field("longest_span", want.longest, out_tdata[75:44]);
      end
    end
  end

  // no request, result or register write for too long means the block is stuck
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("stuck for %0d cycles with %0d reports owed", quiet_cycles,
                 pending_span_reports.size());
        $display("bounded_set_min_max_gap_core_test NOT OK");
        $finish;
      end
    end
  end

  initial begin : run_tests
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    reset_set_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_span_corner_values();
    test_capacity_rules();
    test_output_backpressure();
    test_random_streams();

    // let anything stray come out before judging
    wait_until_drained();
    repeat (20) @(negedge clk);

    $display("covered %0d requests, %0d results, %0d capacity settings, %0d adds refused",
             requests_sent, results_seen, capacity_writes, rejected_adds);
    $display("set grew to %0d values; four idling mixes and one long result-side hold",
             peak_count);
    if (mismatches == 0)
      $display("bounded_set_min_max_gap_core_test OK");
    else
      $display("bounded_set_min_max_gap_core_test NOT OK");
    $finish;
  end

endmodule
